FILE: rtl/core/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared constants, controller states, command/status bundles and helper
// functions for the minimum partition difference block.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int MAX_SUM_DEF  = 4096;
  localparam int MAX_COIN_DEF = 511;
  localparam int WORD_W       = 64;
  localparam int COIN_W       = 9;
  localparam int DIFF_W       = 12;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_PRIME,
    ST_UPDATE,
    ST_DRAIN,
    ST_POST,
    ST_SCAN
  } mpd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;          // latch the input coin
    logic commit;        // update running total and overflow flag
    logic clr_wr;        // write one cleared bitmap word
    logic set_clear;     // zero total and overflow flag
    logic cnt_load_top;  // word counter to top word
    logic cnt_load_half; // word counter to the word holding total/2
    logic cnt_dec;       // step word counter down
    logic upd_prime;     // fetch first source word
    logic upd_rd;        // fetch destination and source words
    logic scan_rd;       // fetch a word for the scan
    logic scan_take;     // capture the best sum on a hit
    logic out_load;      // load the result register
  } mpd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic upd_req;   // coin changes the bitmap
    logic last;      // latched coin closes its set
    logic ovf;       // set has overflowed
    logic cnt_zero;  // word counter at zero
    logic hit;       // scan found a reachable sum
    logic out_free;  // result register can take a new value
  } mpd_sts_t;

  // Index of the highest set bit
  function automatic logic [5:0] mpd_msb(input logic [WORD_W-1:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) begin
        idx = 6'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/min_partition_difference.sv
// ----------------------------------------------------------------------------
// min_partition_difference
// Subset-sum minimum partition difference over a set of coins.
// ----------------------------------------------------------------------------
// Coin handling: a coin that changes the bitmap gets a read-modify-write pass
//   over the bitmap RAM (WORDS = MAX_SUM/64), one word per cycle, and the next
//   coin is taken only after that pass. A zero coin or an overflowing coin
//   skips the pass.
// Result: follows the last coin's update pass, any wait for the previous result
//   to be taken and a descending scan from the word holding total/2; then a
//   clearing sweep runs before the next coin. An overflowed set is not scanned.
// Reset: synchronous active-low rst_n; a clearing sweep of the bitmap runs
//   with in_stall high before first input.
// ----------------------------------------------------------------------------
module min_partition_difference import mpd_pkg::*; #(
  parameter int MAX_SUM  = MAX_SUM_DEF,
  parameter int MAX_COIN = MAX_COIN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // coin input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [COIN_W-1:0] in_coin_value,
  input  logic              in_last_coin,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DIFF_W-1:0] out_min_difference,
  output logic              out_overflow
);

  // Command and status bundles between sequencer and datapath
  mpd_cmd_t cmd;
  mpd_sts_t sts;

  // Sequencer: takes a transfer only in idle, walks the bitmap words top down
  // for each coin that changes it, then scans unless overflowed and clears per set.
  mpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: bitmap RAMs, total, scan and the result register, which
  // holds a result while the next set's coins are already being taken.
  mpd_datapath #(
    .MAX_SUM  (MAX_SUM),
    .MAX_COIN (MAX_COIN)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_coin_value      (in_coin_value),
    .in_last_coin       (in_last_coin),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_min_difference (out_min_difference),
    .out_overflow       (out_overflow)
  );

endmodule

FILE: rtl/core/mpd_ram.sv
// ----------------------------------------------------------------------------
// mpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/mpd_datapath.sv
// ----------------------------------------------------------------------------
// mpd_datapath
// Bitmap of reachable sums in two mirrored RAMs, shift-OR word update,
// running total, descending scan for the best half sum, result register.
// ----------------------------------------------------------------------------
module mpd_datapath import mpd_pkg::*; #(
  parameter int MAX_SUM  = MAX_SUM_DEF,
  parameter int MAX_COIN = MAX_COIN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mpd_cmd_t          cmd,
  output mpd_sts_t          sts,
  input  logic [COIN_W-1:0] in_coin_value,
  input  logic              in_last_coin,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [DIFF_W-1:0] out_min_difference,
  output logic              out_overflow
);

  localparam int WORDS = (MAX_SUM + WORD_W - 1) / WORD_W;
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TW    = $clog2(MAX_SUM);
  localparam int NW    = ((TW > COIN_W) ? TW : COIN_W) + 1;
  localparam int BW    = WIW + 6;
  localparam int XW    = BW + 1;
  localparam int QW    = COIN_W - 6;
  localparam int SW    = ((WIW > QW) ? WIW : QW) + 2;

  localparam logic [WIW-1:0] TOP_WORD = WIW'(WORDS - 1);

  logic [COIN_W-1:0] coin_r;
  logic              last_r;
  logic [TW-1:0]     total_r;
  logic              ovf_r;
  logic [WIW-1:0]    cnt_r;
  logic [WIW-1:0]    cnt_nxt;

  logic              upd_pend_r;
  logic [WIW-1:0]    upd_w_r;
  logic              src_vld_r;
  logic [WORD_W-1:0] src_prev_r;
  logic              scan_pend_r;
  logic [WIW-1:0]    scan_w_r;
  logic [BW-1:0]     best_r;
  logic [BW-1:0]     best_nxt;

  logic              out_valid_r;
  logic [DIFF_W-1:0] out_min_r;
  logic              out_ovf_r;

  logic [COIN_W-1:0] coin_clamped;
  logic [NW-1:0]     next_sum;
  logic              too_big;
  logic              upd_req;

  logic signed [SW-1:0] src_idx;
  logic [WIW-1:0]    src_addr;

  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;
  logic [WORD_W-1:0] src_word;
  logic [2*WORD_W-1:0] cat_shift;
  logic [WORD_W-1:0] upd_word;

  logic              wr_en;
  logic [WIW-1:0]    wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [BW-1:0]     half;
  logic [WIW-1:0]    half_word;
  logic [5:0]        half_bit;
  logic [WORD_W-1:0] scan_mask;
  logic [WORD_W-1:0] scan_word;
  logic              hit;

  logic [XW-1:0]        diff;
  logic [XW+DIFF_W-1:0] diff_ext;
  logic [DIFF_W-1:0]    out_min_nxt;

  // Clamp the coin to the largest legal value
  assign coin_clamped = ({8'd0, in_coin_value} > 17'(MAX_COIN)) ?
                        COIN_W'(MAX_COIN) : in_coin_value;

  assign next_sum = NW'(total_r) + NW'(coin_r);
  assign too_big  = next_sum > NW'(MAX_SUM - 1);
  assign upd_req  = !ovf_r && (coin_r != '0) && !too_big;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      coin_r <= coin_clamped;
      last_r <= in_last_coin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.set_clear) begin
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.commit) begin
      if (upd_req) begin
        total_r <= next_sum[TW-1:0];
      end
      if (!ovf_r && (coin_r != '0) && too_big) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Word counter shared by clear, update and scan
  assign half      = BW'(total_r) >> 1;
  assign half_word = half[BW-1:6];
  assign half_bit  = half[5:0];

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_load_top) begin
      cnt_nxt = TOP_WORD;
    end else if (cmd.cnt_load_half) begin
      cnt_nxt = half_word;
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= TOP_WORD;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Source word index: cnt - q on the priming fetch, cnt - q - 1 after
  assign src_idx  = SW'(cnt_r) - SW'(coin_r[COIN_W-1:6]) - SW'(cmd.upd_rd);
  assign src_addr = src_idx[WIW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_pend_r  <= 1'b0;
      src_vld_r   <= 1'b0;
      scan_pend_r <= 1'b0;
    end else begin
      upd_pend_r  <= cmd.upd_rd;
      src_vld_r   <= (cmd.upd_prime || cmd.upd_rd) && !src_idx[SW-1];
      scan_pend_r <= cmd.scan_rd;
    end
  end

  assign src_word = src_vld_r ? rdata_b : '0;

  always_ff @(posedge clk) begin
    upd_w_r    <= cnt_r;
    scan_w_r   <= cnt_r;
    src_prev_r <= src_word;
  end

  // New word = old | (bitmap shifted up by the coin), from two source words
  assign cat_shift = {src_prev_r, src_word} << coin_r[5:0];
  assign upd_word  = rdata_a | cat_shift[2*WORD_W-1:WORD_W];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = upd_w_r;
    wr_data = upd_word;
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r;
      wr_data = (cnt_r == '0) ? WORD_W'(1) : '0;
    end else if (upd_pend_r) begin
      wr_en   = 1'b1;
    end
  end

  mpd_ram #(.WIDTH(WORD_W), .DEPTH(WORDS), .AW(WIW)) u_ram_dst (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (cnt_r),
    .rdata (rdata_a)
  );

  mpd_ram #(.WIDTH(WORD_W), .DEPTH(WORDS), .AW(WIW)) u_ram_src (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (src_addr),
    .rdata (rdata_b)
  );

  // Scan: keep only sums up to total/2 in the top scanned word
  assign scan_mask = {WORD_W{1'b1}} >> (6'd63 - half_bit);
  assign scan_word = (scan_w_r == half_word) ? (rdata_a & scan_mask) : rdata_a;
  assign hit       = scan_pend_r && (scan_word != '0);

  // Pass the hit straight through so a result loaded on the hit uses it
  assign best_nxt = (cmd.scan_take && hit) ? {scan_w_r, mpd_msb(scan_word)} : best_r;

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign diff        = XW'(total_r) - {best_nxt, 1'b0};
  assign diff_ext    = {{DIFF_W{1'b0}}, diff};
  assign out_min_nxt = ovf_r ? '0 : diff_ext[DIFF_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_min_r <= out_min_nxt;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_min_difference = out_min_r;
  assign out_overflow       = out_ovf_r;

  assign sts.upd_req  = upd_req;
  assign sts.last     = last_r;
  assign sts.ovf      = ovf_r;
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.hit      = hit;
  assign sts.out_free = !out_valid_r || !out_stall;

  a_no_wr_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_wr && upd_pend_r))
    else $error("clear write collides with update write");

  a_total_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= 32'(MAX_SUM - 1))
    else $error("running total beyond bitmap");

  a_ovf_holds_total: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r && !cmd.set_clear |=> $stable(total_r))
    else $error("total moved after overflow");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten");

endmodule

FILE: rtl/core/mpd_ctrl.sv
// ----------------------------------------------------------------------------
// mpd_ctrl
// Sequencer: clearing sweep, per-coin update pass, scan and result hand-off.
// ----------------------------------------------------------------------------
module mpd_ctrl import mpd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mpd_sts_t sts,
  output mpd_cmd_t cmd
);

  mpd_state_t state_r;
  mpd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (sts.cnt_zero) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = sts.upd_req ? ST_PRIME : ST_POST;
      ST_PRIME:  state_nxt = ST_UPDATE;
      ST_UPDATE: if (sts.cnt_zero) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_POST;
      ST_POST: begin
        if (!sts.last) begin
          state_nxt = ST_IDLE;
        end else if (sts.ovf) begin
          if (sts.out_free) state_nxt = ST_CLEAR;
        end else if (sts.out_free) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN:   if (sts.hit) state_nxt = ST_CLEAR;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_dec = 1'b1;
        if (sts.cnt_zero) cmd.set_clear = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_EVAL: begin
        cmd.commit       = 1'b1;
        cmd.cnt_load_top = 1'b1;
      end
      ST_PRIME: cmd.upd_prime = 1'b1;
      ST_UPDATE: begin
        cmd.upd_rd  = 1'b1;
        cmd.cnt_dec = 1'b1;
      end
      ST_DRAIN: ;
      ST_POST: begin
        // Start the scan only once the result register is free, so it stays
        // free for the whole scan
        if (sts.last && sts.ovf && sts.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.cnt_load_top = 1'b1;
        end else if (sts.last && !sts.ovf && sts.out_free) begin
          cmd.cnt_load_half = 1'b1;
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          cmd.scan_take    = 1'b1;
          cmd.out_load     = 1'b1;
          cmd.cnt_load_top = 1'b1;
        end else begin
          cmd.scan_rd = 1'b1;
          cmd.cnt_dec = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_take_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == ST_EVAL)
    else $error("coin taken outside idle");

  a_update_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPDATE && sts.cnt_zero |=> state_r == ST_DRAIN)
    else $error("update pass did not drain");

  a_result_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == ST_CLEAR)
    else $error("no clearing sweep after a result");

endmodule
